FILE: src/pse_pkg.sv
package pse_pkg;

    // PTP message types (low nibble of header byte 0)
    localparam logic [3:0] MSG_SYNC     = 4'h0;
    localparam logic [3:0] MSG_FOLLOW   = 4'h8;
    localparam logic [3:0] MSG_DLY_RESP = 4'h9;

    // header and timestamp sizes in bytes
    localparam logic [15:0] HEADER_LEN    = 16'd34;
    localparam logic [15:0] STAMP_LEN     = 16'd10;
    localparam logic [15:0] MIN_STAMP_LEN = HEADER_LEN + STAMP_LEN;

    // timestamp limits
    localparam logic [47:0] MAX_SECONDS = 48'd9_000_000_000;
    localparam logic [31:0] NS_PER_SEC  = 32'd1_000_000_000;
    localparam logic [29:0] NS_MULT     = 30'd1_000_000_000;

    // result kinds
    localparam logic KIND_REQ  = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // result queue geometry
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // decoded and pre-multiplied message held in the input register
    typedef struct packed {
        logic        general;
        logic [3:0]  msg_type;
        logic        len_ok;
        logic        stamp_ok;
        logic        stamp_nz;
        logic [62:0] prod;
        logic [29:0] nanos;
        logic [62:0] local_time;
    } t_s1;

    // one result word
    typedef struct packed {
        logic        kind;
        logic [62:0] t1;
        logic [62:0] t2;
        logic [62:0] t3;
        logic [62:0] t4;
        logic        last;
    } t_result;

    // up to two results written to the queue in one cycle
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

FILE: src/pse_stamp.sv
module pse_stamp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic            i_on_general_port,
    input  logic [7:0]      i_first_byte,
    input  logic [15:0]     i_msg_length,
    input  logic [47:0]     i_ts_seconds,
    input  logic [31:0]     i_ts_nanos,
    input  logic [62:0]     i_local_time_ns,
    input  logic            i_adv,
    output logic            o_valid,
    output pse_pkg::t_s1    o_s1
);
    import pse_pkg::*;

    logic        r_valid;
    logic        w_load;
    t_s1         r_s1;
    t_s1         n_s1;
    logic [63:0] w_prod;

    assign o_stall = r_valid & ~i_adv;
    assign w_load  = i_valid & ~o_stall;

    // seconds above 9e9 never count, so only the low 34 bits are multiplied
    assign w_prod = {30'd0, i_ts_seconds[33:0]} * {34'd0, NS_MULT};

    // decode the message ahead of the register
    always_comb begin
        n_s1.general    = i_on_general_port;
        n_s1.msg_type   = i_first_byte[3:0];
        n_s1.len_ok     = i_msg_length >= HEADER_LEN;
        n_s1.stamp_ok   = (i_msg_length >= MIN_STAMP_LEN) &&
                          (i_ts_seconds <= MAX_SECONDS) &&
                          (i_ts_nanos < NS_PER_SEC);
        n_s1.stamp_nz   = (i_ts_seconds != 48'd0) || (i_ts_nanos != 32'd0);
        n_s1.prod       = w_prod[62:0];
        n_s1.nanos      = i_ts_nanos[29:0];
        n_s1.local_time = i_local_time_ns;
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_s1 <= n_s1;
        end
    end

    assign o_valid = r_valid;
    assign o_s1    = r_s1;

endmodule

FILE: src/pse_track.sv
module pse_track (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  pse_pkg::t_s1    i_s1,
    output pse_pkg::t_push  o_push
);
    import pse_pkg::*;

    logic [62:0] r_t1, r_t2, r_t3, r_t4;
    logic [62:0] n_t1, n_t2, n_t3, n_t4;
    logic        r_sync_seen, r_t1_known, r_req_sent, r_resp_seen;
    logic        n_sync_seen, n_t1_known, n_req_sent, n_resp_seen;
    logic [62:0] w_ts;
    logic        w_sync, w_fu, w_dr, w_done;
    t_result     w_req_res, w_done_res;

    assign w_ts = i_s1.prod + {33'd0, i_s1.nanos};

    assign w_sync = i_s1.len_ok & ~i_s1.general & (i_s1.msg_type == MSG_SYNC);
    assign w_fu   = i_s1.len_ok & i_s1.general & (i_s1.msg_type == MSG_FOLLOW) &
                    r_sync_seen & i_s1.stamp_ok;
    assign w_dr   = i_s1.len_ok & i_s1.general & (i_s1.msg_type == MSG_DLY_RESP) &
                    i_s1.stamp_ok;

    // exchange state update and completion check
    always_comb begin
        n_t1        = r_t1;
        n_t2        = r_t2;
        n_t3        = r_t3;
        n_t4        = r_t4;
        n_sync_seen = r_sync_seen;
        n_t1_known  = r_t1_known;
        n_req_sent  = r_req_sent;
        n_resp_seen = r_resp_seen;
        w_done      = 1'b0;
        if (i_take) begin
            if (w_sync) begin
                n_t2        = i_s1.local_time;
                n_t3        = i_s1.local_time;
                n_sync_seen = 1'b1;
                n_req_sent  = 1'b1;
                if (i_s1.stamp_ok && i_s1.stamp_nz) begin
                    n_t1       = w_ts;
                    n_t1_known = 1'b1;
                end else begin
                    n_t1_known = 1'b0;
                end
            end
            if (w_fu) begin
                n_t1       = w_ts;
                n_t1_known = 1'b1;
            end
            if (w_dr) begin
                n_t4        = w_ts;
                n_resp_seen = 1'b1;
            end
            w_done = n_sync_seen & n_t1_known & n_req_sent & n_resp_seen;
            if (w_done) begin
                n_sync_seen = 1'b0;
                n_t1_known  = 1'b0;
                n_req_sent  = 1'b0;
                n_resp_seen = 1'b0;
            end
        end
    end

    // result words
    always_comb begin
        w_req_res.kind  = KIND_REQ;
        w_req_res.t1    = 63'd0;
        w_req_res.t2    = 63'd0;
        w_req_res.t3    = i_s1.local_time;
        w_req_res.t4    = 63'd0;
        w_req_res.last  = ~w_done;

        w_done_res.kind = KIND_DONE;
        w_done_res.t1   = n_t1;
        w_done_res.t2   = n_t2;
        w_done_res.t3   = n_t3;
        w_done_res.t4   = n_t4;
        w_done_res.last = 1'b1;

        o_push.second = w_done_res;
        if (i_take && w_sync) begin
            o_push.first = w_req_res;
            o_push.count = w_done ? 2'd2 : 2'd1;
        end else begin
            o_push.first = w_done_res;
            o_push.count = w_done ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_seen <= 1'b0;
            r_t1_known  <= 1'b0;
            r_req_sent  <= 1'b0;
            r_resp_seen <= 1'b0;
        end else begin
            r_sync_seen <= n_sync_seen;
            r_t1_known  <= n_t1_known;
            r_req_sent  <= n_req_sent;
            r_resp_seen <= n_resp_seen;
        end
    end

    // held stamps are only read under their flags
    always_ff @(posedge i_clk) begin
        r_t1 <= n_t1;
        r_t2 <= n_t2;
        r_t3 <= n_t3;
        r_t4 <= n_t4;
    end

`ifndef SYNTHESIS
    // a double push is always a request followed by a completed exchange
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.count == 2'd2) |->
            (o_push.first.kind == KIND_REQ && o_push.second.kind == KIND_DONE &&
             !o_push.first.last))
        else $error("double push out of order");

    // completion clears every flag
    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && w_done) |=>
            (!r_sync_seen && !r_t1_known && !r_req_sent && !r_resp_seen))
        else $error("flags left set after completion");

    // a request or t1 is only held within a Sync
    a_flags_need_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_req_sent || r_t1_known) |-> r_sync_seen)
        else $error("request or t1 held without Sync");
`endif

endmodule

FILE: src/pse_outq.sv
module pse_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pse_pkg::t_push    i_push,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_stall,
    output pse_pkg::t_result  o_head
);
    import pse_pkg::*;

    t_result              r_mem [QDEPTH];
    logic [QPTR_W-1:0]    r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]    r_count;
    logic [QCNT_W-1:0]    n_count;
    logic                 w_pop;
    logic [QPTR_W-1:0]    w_wr_next;

    assign o_valid   = r_count != '0;
    assign w_pop     = o_valid & ~i_stall;
    assign o_room    = r_count <= QCNT_W'(QDEPTH - 2);
    assign w_wr_next = r_wr_ptr + 1'b1;
    assign n_count   = r_count + QCNT_W'(i_push.count) - QCNT_W'(w_pop);
    assign o_head    = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QPTR_W'(i_push.count);
            r_rd_ptr <= r_rd_ptr + QPTR_W'(w_pop);
            r_count  <= n_count;
        end
    end

    // up to two words written per cycle
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[w_wr_next] <= i_push.second;
        end
    end

`ifndef SYNTHESIS
    // writes only arrive when two slots are free
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |-> o_room)
        else $error("result queue overflow");

    // fill count never exceeds the depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("result queue count out of range");

    // a stalled head is not lost
    a_stall_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(r_rd_ptr)))
        else $error("stalled result dropped");
`endif

endmodule

FILE: src/ptp_slave_exchange_assembler.sv
// Channel   Handshake           Words
// input     i_valid / o_stall   received PTP message: port, byte 0, length, stamp, local time
// output    o_valid / i_stall   delay request to send or completed t1..t4 exchange
//
// One message taken per cycle unless o_stall; results pass the input register and queue.
// Rate is set by the result queue: a Sync that also completes an exchange writes two words.
// o_stall rises while the input register holds a message and the queue has fewer than
// two free slots; the queue drains one word per cycle while i_stall is low.
// Reset (i_rst_n low, synchronous) empties the pipeline and clears all exchange flags.
module ptp_slave_exchange_assembler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_on_general_port,
    input  logic [7:0]  i_first_byte,
    input  logic [15:0] i_msg_length,
    input  logic [47:0] i_ts_seconds,
    input  logic [31:0] i_ts_nanos,
    input  logic [62:0] i_local_time_ns,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_result_kind,
    output logic [62:0] o_t1_master_sync,
    output logic [62:0] o_t2_local_sync,
    output logic [62:0] o_t3_local_req,
    output logic [62:0] o_t4_master_req,
    output logic        o_last_of_run
);
    import pse_pkg::*;

    logic    w_s1_valid;
    t_s1     w_s1;
    logic    w_room;
    logic    w_take;
    t_push   w_push;
    t_result w_head;

    // message moves on when the queue can take its results
    assign w_take = w_s1_valid & w_room;

    pse_stamp u_stamp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_on_general_port (i_on_general_port),
        .i_first_byte      (i_first_byte),
        .i_msg_length      (i_msg_length),
        .i_ts_seconds      (i_ts_seconds),
        .i_ts_nanos        (i_ts_nanos),
        .i_local_time_ns   (i_local_time_ns),
        .i_adv             (w_room),
        .o_valid           (w_s1_valid),
        .o_s1              (w_s1)
    );

    pse_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_s1    (w_s1),
        .o_push  (w_push)
    );

    pse_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_head  (w_head)
    );

    assign o_result_kind    = w_head.kind;
    assign o_t1_master_sync = w_head.t1;
    assign o_t2_local_sync  = w_head.t2;
    assign o_t3_local_req   = w_head.t3;
    assign o_t4_master_req  = w_head.t4;
    assign o_last_of_run    = w_head.last;

endmodule
